>>> hw/rtl/linear_key_value_table_defines.svh
// ----------------------------------------------------------------------------
// linear_key_value_table_defines
// Assertion macros shared by the key/value table modules.
// ----------------------------------------------------------------------------
`ifndef LINEAR_KEY_VALUE_TABLE_DEFINES_SVH
`define LINEAR_KEY_VALUE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, masked while reset is asserted
`define LKV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define LKV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LKV_ASSERT(lbl, clk, rst_n, prop, msg)
`define LKV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hw/rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Types, codes and sizes shared by the key/value table modules.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_SET    = 3'd0,
    OP_RM_KEY = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_RD_IDX = 3'd3,
    OP_RM_IDX = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             found;
    logic [KEY_W-1:0] out_key;
    logic [VAL_W-1:0] out_value;
    logic [IDX_W-1:0] out_index;
    logic [CNT_W-1:0] entry_count;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic search;
    logic read;
    logic fetch_last;
    logic commit;
  } lkv_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_move;
  } lkv_stat_t;

endpackage

>>> hw/rtl/lkv_dp.sv
// ----------------------------------------------------------------------------
// lkv_dp
// Entry registers, parallel key compare, read port and result register.
// ----------------------------------------------------------------------------
`include "linear_key_value_table_defines.svh"

module lkv_dp import lkv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  lkv_cmd_t  cmd,
  output lkv_stat_t stat,
  output out_item_t out_data
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  in_item_t         req_r;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [KEY_W-1:0] ent_key_r, mv_key_r;
  logic [VAL_W-1:0] ent_val_r, mv_val_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  out_item_t        out_r, out_nxt;
  logic [KEY_W-1:0] key_mem_r [CAPACITY];
  logic [VAL_W-1:0] val_mem_r [CAPACITY];

  logic [CNT_W-1:0] last_cnt;
  logic [IDX_W-1:0] last_idx, rd_addr, wr_addr;
  logic             is_remove;
  logic             key_we, val_we;
  logic [KEY_W-1:0] wr_key;
  logic [VAL_W-1:0] wr_val;

  assign last_cnt  = count_r - CNT_W'(1);
  assign last_idx  = last_cnt[IDX_W-1:0];
  assign is_remove = (req_r.operation == OP_RM_KEY) || (req_r.operation == OP_RM_IDX);
  assign stat.need_move = hit_r && is_remove && ({1'b0, pos_r} < last_cnt);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
  end

  // search: first live key match, or index range check
  always_comb begin
    hit_nxt = 1'b0;
    pos_nxt = '0;
    if ((req_r.operation == OP_RD_IDX) || (req_r.operation == OP_RM_IDX)) begin
      hit_nxt = {1'b0, req_r.index} < count_r;
      pos_nxt = req_r.index;
    end else begin
      for (int i = CAPACITY - 1; i >= 0; i--) begin
        if ((CNT_W'(i) < count_r) && (key_mem_r[i] == req_r.key)) begin
          hit_nxt = 1'b1;
          pos_nxt = IDX_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      hit_r <= hit_nxt;
      pos_r <= pos_nxt;
    end
  end

  // single registered read port: matched entry, then last entry
  assign rd_addr = cmd.fetch_last ? last_idx : pos_r;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      ent_key_r <= key_mem_r[rd_addr];
      ent_val_r <= val_mem_r[rd_addr];
    end
    if (cmd.fetch_last) begin
      mv_key_r <= key_mem_r[rd_addr];
      mv_val_r <= val_mem_r[rd_addr];
    end
  end

  // commit: entry update, count update and result
  always_comb begin
    out_nxt   = '0;
    count_nxt = count_r;
    key_we    = 1'b0;
    val_we    = 1'b0;
    wr_addr   = pos_r;
    wr_key    = req_r.key;
    wr_val    = req_r.value;
    case (req_r.operation)
      OP_SET: begin
        if (hit_r) begin
          val_we            = 1'b1;
          out_nxt.found     = 1'b1;
          out_nxt.out_key   = req_r.key;
          out_nxt.out_value = req_r.value;
          out_nxt.out_index = pos_r;
        end else if (count_r == CAP_CNT) begin
          out_nxt.status = ST_FULL;
        end else begin
          key_we            = 1'b1;
          val_we            = 1'b1;
          wr_addr           = count_r[IDX_W-1:0];
          out_nxt.out_key   = req_r.key;
          out_nxt.out_value = req_r.value;
          out_nxt.out_index = count_r[IDX_W-1:0];
          count_nxt         = count_r + CNT_W'(1);
        end
      end
      OP_RM_KEY, OP_RM_IDX: begin
        if (hit_r) begin
          out_nxt.found     = 1'b1;
          out_nxt.out_key   = ent_key_r;
          out_nxt.out_value = ent_val_r;
          out_nxt.out_index = pos_r;
          key_we            = stat.need_move;
          val_we            = stat.need_move;
          wr_key            = mv_key_r;
          wr_val            = mv_val_r;
          count_nxt         = last_cnt;
        end else if (req_r.operation == OP_RM_KEY) begin
          out_nxt.status = ST_NOT_FOUND;
        end else begin
          out_nxt.status = ST_RANGE;
        end
      end
      OP_LOOKUP, OP_RD_IDX: begin
        if (hit_r) begin
          out_nxt.found     = 1'b1;
          out_nxt.out_key   = ent_key_r;
          out_nxt.out_value = ent_val_r;
          out_nxt.out_index = pos_r;
        end else if (req_r.operation == OP_LOOKUP) begin
          out_nxt.status = ST_NOT_FOUND;
        end else begin
          out_nxt.status = ST_RANGE;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    out_nxt.entry_count = count_nxt;
  end

  // entry store writes
  always_ff @(posedge clk) begin
    if (cmd.commit && key_we) begin
      key_mem_r[wr_addr] <= wr_key;
    end
    if (cmd.commit && val_we) begin
      val_mem_r[wr_addr] <= wr_val;
    end
  end

  // live entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  `LKV_ASSERT(a_count_bound, clk, rst_n, (count_r <= CAP_CNT), "entry count above capacity")
  `LKV_ASSERT(a_move_in_range, clk, rst_n, (cmd.fetch_last |-> (count_r > CNT_W'(1))), "last entry fetch with fewer than two entries")

endmodule

>>> hw/rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer for one table operation and the result valid flag.
// ----------------------------------------------------------------------------
`include "linear_key_value_table_defines.svh"

module lkv_ctrl import lkv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lkv_stat_t stat,
  output lkv_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SRCH = 5'b00010,
    S_READ = 5'b00100,
    S_LAST = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // handshake and commands
  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign cmd.capture    = in_valid && in_ready;
  assign cmd.search     = (state_r == S_SRCH);
  assign cmd.read       = (state_r == S_READ);
  assign cmd.fetch_last = (state_r == S_LAST);
  assign cmd.commit     = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_SRCH;
      end
      S_SRCH: begin
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = stat.need_move ? S_LAST : S_DONE;
      end
      S_LAST: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LKV_ASSERT(a_accept_starts_search, clk, rst_n, (cmd.capture |=> (state_r == S_SRCH) && !in_ready), "accepted item did not start a search")
  `LKV_ASSERT(a_commit_slot_free, clk, rst_n, (cmd.commit |-> (!out_valid_r || out_ready)), "result written over a pending result")
  `LKV_ASSERT(a_commit_shows_result, clk, rst_n, (cmd.commit |=> out_valid_r && in_ready), "commit did not present a result")

endmodule

>>> hw/rtl/linear_key_value_table.sv
// ----------------------------------------------------------------------------
// linear_key_value_table
// Fixed-capacity key/value table in insertion order with swap-and-pop removal.
// ----------------------------------------------------------------------------
// sequence: an accepted item passes search, read and commit; a removal that
//   moves the last entry into the hole fetches it between read and commit
// intake: the sequencer, which shares the single read port of the entry
//   registers, takes a new item only after the previous one commits
// reset: synchronous rst_n empties the table; entry contents are not cleared
// ----------------------------------------------------------------------------
module linear_key_value_table import lkv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  lkv_cmd_t  cmd;
  lkv_stat_t stat;

  // operation sequencer
  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // entry storage and result datapath
  lkv_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
